@@ rtl/clc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

    typedef enum logic [2:0] {
        OP_INS_PREV,
        OP_INS_NEXT,
        OP_RM_PREV,
        OP_RM_NEXT,
        OP_RM_CUR,
        OP_LIST,
        OP_CLEAR
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_FULL,
        STAT_NONB
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_A,
        ST_INS_B,
        ST_INS_C,
        ST_INS_F,
        ST_RN_A,
        ST_RN_B,
        ST_RN_C,
        ST_RC_A,
        ST_RC_B,
        ST_RC_L,
        ST_LS_A,
        ST_LS_B,
        ST_LS_C,
        ST_CLR,
        ST_E_OK,
        ST_E_FULL,
        ST_E_EMPTY,
        ST_E_NONB
    } step_t;

    typedef enum logic [2:0] {
        RA_NONE,
        RA_CUR,
        RA_SEL,
        RA_PRV,
        RA_NXT
    } rsel_t;

    typedef enum logic [2:0] {
        A_NONE,
        A_INS_PN,
        A_INS_E,
        A_FIRST,
        A_UNLINK,
        A_LONE,
        A_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_EMPTY,
        C_SELF,
        C_LONE,
        C_MORE
    } cond_t;

    typedef struct packed {
        rsel_t   ra;
        logic    fs_pop;
        logic    ld_v;
        act_t    act;
        logic    mv_cur;
        logic    ls_start;
        logic    emit;
        status_t status;
        logic    dsel_val;
        logic    walk;
        cond_t   cond;
        logic    guard;
        step_t   target;
        logic    done;
    } cw_t;

    typedef struct packed {
        logic go;
        logic load;
        cw_t  cw;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic self_nb;
        logic lone;
        logic more;
        logic out_free;
    } flags_t;

    function automatic step_t entry(input logic [2:0] op, input logic full,
                                    input logic empty);
        step_t s;
        s = ST_E_OK;
        unique case (op) inside
            OP_INS_PREV, OP_INS_NEXT: s = full ? ST_E_FULL : ST_INS_A;
            OP_RM_PREV, OP_RM_NEXT:   s = empty ? ST_E_EMPTY : ST_RN_A;
            OP_RM_CUR:                s = empty ? ST_E_EMPTY : ST_RC_A;
            OP_LIST:                  s = empty ? ST_E_EMPTY : ST_LS_A;
            OP_CLEAR:                 s = ST_CLR;
            default:                  s = ST_E_OK;
        endcase
        return s;
    endfunction

    // Control store: one word per step. A taken jump with guard set skips the step's work.
    function automatic cw_t prog(input step_t s);
        cw_t c;
        c = '0;
        unique case (s)
            ST_INS_A: begin
                c.ra     = RA_CUR;
                c.fs_pop = 1'b1;
            end
            ST_INS_B: begin
                c.act    = A_INS_PN;
                c.cond   = C_EMPTY;
                c.guard  = 1'b1;
                c.target = ST_INS_F;
            end
            ST_INS_C: begin
                c.act  = A_INS_E;
                c.emit = 1'b1;
                c.done = 1'b1;
            end
            ST_INS_F: begin
                c.act  = A_FIRST;
                c.emit = 1'b1;
                c.done = 1'b1;
            end
            ST_RN_A: begin
                c.ra = RA_CUR;
            end
            ST_RN_B: begin
                c.ra     = RA_SEL;
                c.ld_v   = 1'b1;
                c.cond   = C_SELF;
                c.guard  = 1'b1;
                c.target = ST_E_NONB;
            end
            ST_RN_C: begin
                c.act      = A_UNLINK;
                c.emit     = 1'b1;
                c.dsel_val = 1'b1;
                c.done     = 1'b1;
            end
            ST_RC_A: begin
                c.ra   = RA_CUR;
                c.ld_v = 1'b1;
            end
            ST_RC_B: begin
                c.act      = A_UNLINK;
                c.mv_cur   = 1'b1;
                c.emit     = 1'b1;
                c.dsel_val = 1'b1;
                c.cond     = C_LONE;
                c.guard    = 1'b1;
                c.target   = ST_RC_L;
                c.done     = 1'b1;
            end
            ST_RC_L: begin
                c.act      = A_LONE;
                c.emit     = 1'b1;
                c.dsel_val = 1'b1;
                c.done     = 1'b1;
            end
            ST_LS_A: begin
                c.ra = RA_CUR;
            end
            ST_LS_B: begin
                c.ra       = RA_PRV;
                c.ls_start = 1'b1;
            end
            ST_LS_C: begin
                c.ra       = RA_NXT;
                c.emit     = 1'b1;
                c.dsel_val = 1'b1;
                c.walk     = 1'b1;
                c.cond     = C_MORE;
                c.target   = ST_LS_C;
                c.done     = 1'b1;
            end
            ST_CLR: begin
                c.act  = A_CLEAR;
                c.emit = 1'b1;
                c.done = 1'b1;
            end
            ST_E_OK: begin
                c.emit = 1'b1;
                c.done = 1'b1;
            end
            ST_E_FULL: begin
                c.emit   = 1'b1;
                c.status = STAT_FULL;
                c.done   = 1'b1;
            end
            ST_E_EMPTY: begin
                c.emit   = 1'b1;
                c.status = STAT_EMPTY;
                c.done   = 1'b1;
            end
            ST_E_NONB: begin
                c.emit   = 1'b1;
                c.status = STAT_NONB;
                c.done   = 1'b1;
            end
            default: ;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/circular_list_with_cursor_unit.sv @@
// Channel   Dir  Signals                      Beat contents
// s         in   s_tvalid s_tready s_tdata    one operation: value, opcode in s_tuser
//                s_tuser
// m         out  m_tvalid m_tready m_tdata    one result: data_out, status, at_cursor,
//                m_tlast                      now_empty; m_tlast marks the final result
//
// One operation is taken in an idle cycle and then run by the step sequencer.
// Inserts run the INS steps, removes the RN or RC steps, and clear and error results
// are emitted straight from their entry step. A list walks the ring node by node, as
// the link memories have a single read port that the walk goes through.
// Reset is asynchronous and leaves an empty list with the full node pool free.
// A result waiting on m_tready stalls only the step that wants to emit the next one.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_with_cursor_unit #(
    parameter int CAPACITY  = 32,
    parameter int DATA_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // value[15:0]
    input  logic [2:0]  s_tuser,  // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // data_out[15:0], status[17:16], at_cursor[18],
                                  // now_empty[19], zero[23:20]
    output logic        m_tlast
);

    clc_pkg::step_t  step_reg, step_next;
    clc_pkg::cw_t    cw;
    clc_pkg::ctl_t   ctl;
    clc_pkg::flags_t flags;
    logic            s_fire, taken, stall, go;

    assign cw       = clc_pkg::prog(step_reg);
    assign s_tready = (step_reg == clc_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        unique case (cw.cond)
            clc_pkg::C_EMPTY: taken = flags.empty;
            clc_pkg::C_SELF:  taken = flags.self_nb;
            clc_pkg::C_LONE:  taken = flags.lone;
            clc_pkg::C_MORE:  taken = flags.more;
            default:          taken = 1'b0;
        endcase
    end

    assign stall = cw.emit && !flags.out_free;
    assign go    = (step_reg != clc_pkg::ST_IDLE) && !stall && !(taken && cw.guard);

    always_comb
    begin
        if (s_fire)
        begin
            step_next = clc_pkg::entry(s_tuser, flags.full, flags.empty);
        end
        else if ((step_reg == clc_pkg::ST_IDLE) || stall)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = cw.target;
        end
        else if (cw.done)
        begin
            step_next = clc_pkg::ST_IDLE;
        end
        else
        begin
            step_next = clc_pkg::step_t'(step_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= clc_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.go   = go;
    assign ctl.load = s_fire;
    assign ctl.cw   = cw;

    clc_datapath #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .side     (s_tuser[0]),
        .value    (s_tdata),
        .flags    (flags),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/clc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clc_datapath #(
    parameter int CAPACITY  = 32,
    parameter int DATA_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clc_pkg::ctl_t   ctl,
    input  logic            side,
    input  logic [15:0]     value,
    output clc_pkg::flags_t flags,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [23:0]     m_tdata,
    output logic            m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic [DATA_BITS-1:0] val_mem [CAPACITY];
    logic [IW-1:0]        nxt_mem [CAPACITY];
    logic [IW-1:0]        prv_mem [CAPACITY];
    logic [IW-1:0]        fs_mem  [CAPACITY];

    logic [DATA_BITS-1:0] val_rd;
    logic [IW-1:0]        nxt_rd;
    logic [IW-1:0]        prv_rd;
    logic [IW-1:0]        fs_rd;
    logic                 fs_vld_rd;
    logic [IW-1:0]        fs_idx_rd;

    logic [IW-1:0]        cur_reg, cur_next;
    logic                 has_reg, has_next;
    logic [CW-1:0]        fcnt_reg, fcnt_next;
    logic [CAPACITY-1:0]  fs_vld_reg, fs_vld_next;
    logic                 out_vld_reg, out_vld_next;

    logic                 side_reg;
    logic [DATA_BITS-1:0] val_in_reg;
    logic [IW-1:0]        v_reg, e_reg, p_reg, n_reg, t_reg, start_reg;
    logic [15:0]          out_data_reg;
    clc_pkg::status_t     out_stat_reg;
    logic                 out_atc_reg, out_last_reg, out_empty_reg;

    clc_pkg::cw_t         cw;
    logic                 go;
    logic [IW-1:0]        fs_out, sel, ra_addr, pop_idx, rel_idx;
    logic [IW-1:0]        p_pn, n_pn;
    logic                 rd_en, pop_en, rel_en, emit_load;
    logic                 vl_we, nx_we, pv_we;
    logic [IW-1:0]        vl_wa, nx_wa, nx_wd, pv_wa, pv_wd;
    logic [DATA_BITS+15:0] in_wide, rd_wide;

    assign cw = ctl.cw;
    assign go = ctl.go;

    assign in_wide = {{DATA_BITS{1'b0}}, value};
    assign rd_wide = {16'b0, val_rd};

    assign fs_out  = fs_vld_rd ? fs_rd : fs_idx_rd;
    assign sel     = side_reg ? nxt_rd : prv_rd;
    assign p_pn    = side_reg ? cur_reg : prv_rd;
    assign n_pn    = side_reg ? nxt_rd : cur_reg;
    assign pop_idx = IW'(fcnt_reg - 1'b1);
    assign rel_idx = IW'(fcnt_reg);

    always_comb
    begin
        unique case (cw.ra)
            clc_pkg::RA_CUR: ra_addr = cur_reg;
            clc_pkg::RA_SEL: ra_addr = sel;
            clc_pkg::RA_PRV: ra_addr = prv_rd;
            clc_pkg::RA_NXT: ra_addr = nxt_rd;
            default:         ra_addr = cur_reg;
        endcase
    end

    assign rd_en     = go && (cw.ra != clc_pkg::RA_NONE);
    assign pop_en    = go && cw.fs_pop;
    assign rel_en    = go && ((cw.act == clc_pkg::A_UNLINK) || (cw.act == clc_pkg::A_LONE))
                       && (fcnt_reg < FULL_CNT);
    assign emit_load = go && cw.emit;

    always_comb
    begin
        vl_we = 1'b0;
        vl_wa = fs_out;
        nx_we = 1'b0;
        nx_wa = p_pn;
        nx_wd = fs_out;
        pv_we = 1'b0;
        pv_wa = n_pn;
        pv_wd = fs_out;
        if (go)
        begin
            unique case (cw.act)
                clc_pkg::A_INS_PN: begin
                    vl_we = 1'b1;
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                end
                clc_pkg::A_INS_E: begin
                    nx_we = 1'b1;
                    nx_wa = e_reg;
                    nx_wd = n_reg;
                    pv_we = 1'b1;
                    pv_wa = e_reg;
                    pv_wd = p_reg;
                end
                clc_pkg::A_FIRST: begin
                    vl_we = 1'b1;
                    nx_we = 1'b1;
                    nx_wa = fs_out;
                    pv_we = 1'b1;
                    pv_wa = fs_out;
                end
                clc_pkg::A_UNLINK: begin
                    nx_we = 1'b1;
                    nx_wa = prv_rd;
                    nx_wd = nxt_rd;
                    pv_we = 1'b1;
                    pv_wa = nxt_rd;
                    pv_wd = prv_rd;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cur_next    = cur_reg;
        has_next    = has_reg;
        fcnt_next   = fcnt_reg;
        fs_vld_next = fs_vld_reg;
        if (go)
        begin
            if (cw.mv_cur && (cw.act == clc_pkg::A_UNLINK))
            begin
                cur_next = prv_rd;
            end
            unique case (cw.act)
                clc_pkg::A_FIRST: begin
                    cur_next = fs_out;
                    has_next = 1'b1;
                end
                clc_pkg::A_LONE: begin
                    cur_next = '0;
                    has_next = 1'b0;
                end
                clc_pkg::A_CLEAR: begin
                    cur_next    = '0;
                    has_next    = 1'b0;
                    fcnt_next   = FULL_CNT;
                    fs_vld_next = '0;
                end
                default: ;
            endcase
            if (pop_en)
            begin
                fcnt_next = fcnt_reg - 1'b1;
            end
            if (rel_en)
            begin
                fcnt_next            = fcnt_reg + 1'b1;
                fs_vld_next[rel_idx] = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            has_reg     <= 1'b0;
            fcnt_reg    <= FULL_CNT;
            fs_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            has_reg     <= has_next;
            fcnt_reg    <= fcnt_next;
            fs_vld_reg  <= fs_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vl_we)
        begin
            val_mem[vl_wa] <= val_in_reg;
        end
        if (nx_we)
        begin
            nxt_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prv_mem[pv_wa] <= pv_wd;
        end
        if (rd_en)
        begin
            val_rd <= val_mem[ra_addr];
            nxt_rd <= nxt_mem[ra_addr];
            prv_rd <= prv_mem[ra_addr];
            t_reg  <= ra_addr;
            if (cw.ld_v)
            begin
                v_reg <= ra_addr;
            end
        end
        if (pop_en)
        begin
            fs_rd     <= fs_mem[pop_idx];
            fs_vld_rd <= fs_vld_reg[pop_idx];
            fs_idx_rd <= pop_idx;
        end
        if (rel_en)
        begin
            fs_mem[rel_idx] <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            side_reg   <= side;
            val_in_reg <= in_wide[DATA_BITS-1:0];
        end
        if (go && (cw.act == clc_pkg::A_INS_PN))
        begin
            e_reg <= fs_out;
            p_reg <= p_pn;
            n_reg <= n_pn;
        end
        if (go && cw.ls_start)
        begin
            start_reg <= prv_rd;
        end
        if (emit_load)
        begin
            out_data_reg  <= cw.dsel_val ? rd_wide[15:0] : 16'b0;
            out_stat_reg  <= cw.status;
            out_atc_reg   <= cw.walk && (t_reg == cur_reg);
            out_last_reg  <= cw.walk ? (nxt_rd == start_reg) : 1'b1;
            out_empty_reg <= !has_next;
        end
    end

    assign flags.full     = (fcnt_reg == '0);
    assign flags.empty    = !has_reg;
    assign flags.self_nb  = (sel == cur_reg);
    assign flags.lone     = (nxt_rd == cur_reg);
    assign flags.more     = (nxt_rd != start_reg);
    assign flags.out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, out_empty_reg, out_atc_reg, out_stat_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
